// ===== rtl/mfv_pkg.sv =====
// Package for the meter frame validator: frame constants, status codes,
// register indexes and the structs shared by the datapath and the top level.
// Depends on nothing.
package mfv_pkg;

    // Frame layout
    localparam int unsigned MAX_FRAME = 256;
    localparam int unsigned MIN_FRAME = 12;

    localparam logic [7:0] HEAD_MARK = 8'h68;
    localparam logic [7:0] END_MARK  = 8'h16;
    localparam logic [7:0] ANY_BYTE  = 8'hAA;
    localparam int unsigned DIR_BIT  = 7;

    localparam logic [8:0] POS_FIRST_HEAD  = 9'd0;
    localparam logic [8:0] POS_SECOND_HEAD = 9'd7;
    localparam logic [8:0] POS_CTRL        = 9'd8;
    localparam logic [8:0] POS_LEN         = 9'd9;
    localparam logic [8:0] SUM_BASE        = 9'd10;
    localparam logic [8:0] MIN_FRAME_W     = 9'(MIN_FRAME);
    localparam logic [8:0] MAX_FRAME_W     = 9'(MAX_FRAME);

    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned CFG_IDX_W = 2;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_INCOMPLETE    = 3'd1,
        ST_BAD_HEAD      = 3'd2,
        ST_TOO_LONG      = 3'd3,
        ST_WRONG_DIR     = 3'd4,
        ST_BAD_END       = 3'd5,
        ST_BAD_SUM       = 3'd6,
        ST_ADDR_MISMATCH = 3'd7
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECT_DOWNLINK  = 2'd0,
        CFG_ADDRESS_CHECK_ON = 2'd1,
        CFG_TARGET_ADDRESS   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic              expect_downlink;
        logic              address_check_on;
        logic [ADDR_W-1:0] target_address;
    } t_cfg;

    typedef struct packed {
        logic [8:0] byte_index;
        logic [7:0] data_length;
        logic [7:0] control_byte;
        logic [7:0] running_sum;
        logic       head_good;
        logic       address_good;
        logic       sum_good;
    } t_frame_state;

    localparam t_frame_state FRAME_CLEAR = '{
        byte_index:   9'd0,
        data_length:  8'd0,
        control_byte: 8'd0,
        running_sum:  8'd0,
        head_good:    1'b1,
        address_good: 1'b1,
        sum_good:     1'b0
    };

    typedef struct packed {
        logic       valid;
        t_status    status;
        logic [8:0] frame_length;
    } t_verdict;

endpackage

// ===== rtl/mfv_in_if.sv =====
// Byte channel into the meter frame validator: valid/ready plus one frame byte.
// Depends on nothing.
interface mfv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// ===== rtl/mfv_out_if.sv =====
// Verdict channel out of the meter frame validator: valid/ready plus the result.
// Depends on nothing.
interface mfv_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [8:0] frame_length;

    modport source (output valid, output status, output frame_length, input ready);
    modport sink   (input valid, input status, input frame_length, output ready);
endinterface

// ===== rtl/mfv_step.sv =====
// Per-byte datapath of the meter frame validator: next frame state and verdict.
// Depends on mfv_pkg.
module mfv_step (
    input  mfv_pkg::t_frame_state i_state,
    input  mfv_pkg::t_cfg         i_cfg,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_buffer_end,
    output mfv_pkg::t_frame_state o_state,
    output mfv_pkg::t_verdict     o_verdict
);

    logic [8:0]          idx;
    logic [8:0]          nidx;
    logic [8:0]          sum_pos;
    logic [8:0]          flen;
    logic [7:0]          target_byte;
    logic                up;
    mfv_pkg::t_frame_state upd;
    mfv_pkg::t_verdict     vd;

    assign idx  = i_state.byte_index;
    assign nidx = idx + 9'd1;

    // Pick the target byte that lines up with the current address byte
    always_comb begin
        case (idx[2:0])
            3'd1:    target_byte = i_cfg.target_address[7:0];
            3'd2:    target_byte = i_cfg.target_address[15:8];
            3'd3:    target_byte = i_cfg.target_address[23:16];
            3'd4:    target_byte = i_cfg.target_address[31:24];
            3'd5:    target_byte = i_cfg.target_address[39:32];
            3'd6:    target_byte = i_cfg.target_address[47:40];
            default: target_byte = mfv_pkg::ANY_BYTE;
        endcase
    end

    // Capture header fields and track the head, address and sum checks
    always_comb begin
        upd = i_state;
        if (idx == mfv_pkg::POS_FIRST_HEAD || idx == mfv_pkg::POS_SECOND_HEAD) begin
            if (i_rx_byte != mfv_pkg::HEAD_MARK) begin
                upd.head_good = 1'b0;
            end
        end else if (idx < mfv_pkg::POS_SECOND_HEAD) begin
            if (target_byte != mfv_pkg::ANY_BYTE && target_byte != i_rx_byte) begin
                upd.address_good = 1'b0;
            end
        end else if (idx == mfv_pkg::POS_CTRL) begin
            upd.control_byte = i_rx_byte;
        end else if (idx == mfv_pkg::POS_LEN) begin
            upd.data_length = i_rx_byte;
        end

        sum_pos = mfv_pkg::SUM_BASE + {1'b0, upd.data_length};
        if (idx < sum_pos) begin
            upd.running_sum = upd.running_sum + i_rx_byte;
        end else if (idx == sum_pos) begin
            upd.sum_good = (i_rx_byte == upd.running_sum);
        end
        upd.byte_index = nidx;
    end

    // Decide the verdict in the order short frame, head, length, end checks, buffer end
    always_comb begin
        flen            = {1'b0, upd.data_length} + mfv_pkg::MIN_FRAME_W;
        up              = upd.control_byte[mfv_pkg::DIR_BIT];
        vd.valid        = 1'b0;
        vd.status       = mfv_pkg::ST_OK;
        vd.frame_length = 9'd0;
        if (nidx < mfv_pkg::MIN_FRAME_W) begin
            if (i_buffer_end) begin
                vd.valid  = 1'b1;
                vd.status = mfv_pkg::ST_INCOMPLETE;
            end
        end else if (nidx == mfv_pkg::MIN_FRAME_W && !upd.head_good) begin
            vd.valid  = 1'b1;
            vd.status = mfv_pkg::ST_BAD_HEAD;
        end else if (nidx == mfv_pkg::MIN_FRAME_W && flen > mfv_pkg::MAX_FRAME_W) begin
            vd.valid  = 1'b1;
            vd.status = mfv_pkg::ST_TOO_LONG;
        end else if (nidx >= flen) begin
            vd.valid = 1'b1;
            if (up == i_cfg.expect_downlink) begin
                vd.status = mfv_pkg::ST_WRONG_DIR;
            end else if (i_rx_byte != mfv_pkg::END_MARK) begin
                vd.status = mfv_pkg::ST_BAD_END;
            end else if (!upd.sum_good) begin
                vd.status = mfv_pkg::ST_BAD_SUM;
            end else if (i_cfg.address_check_on && !upd.address_good) begin
                vd.status       = mfv_pkg::ST_ADDR_MISMATCH;
                vd.frame_length = flen;
            end else begin
                vd.status       = mfv_pkg::ST_OK;
                vd.frame_length = flen;
            end
        end else if (i_buffer_end) begin
            vd.valid  = 1'b1;
            vd.status = mfv_pkg::ST_INCOMPLETE;
        end
    end

    // Any verdict starts a new frame with the next byte
    assign o_state   = vd.valid ? mfv_pkg::FRAME_CLEAR : upd;
    assign o_verdict = vd;

endmodule

// ===== rtl/meter_frame_validator.sv =====
// Top level of the meter frame validator: frame state, configuration
// registers and the registered verdict. Depends on mfv_pkg, mfv_in_if,
// mfv_out_if and mfv_step.
//
// The block takes one frame byte per clock cycle and gives at most one
// verdict per byte, in the cycle after the byte is accepted, from a single
// output register. Per byte it only compares, adds into the 8-bit sum and
// steps the byte counter, so bytes may follow back to back; the input is
// held off only while a verdict sits in the output register and the sink
// does not take it. After every verdict the next byte opens a new frame.
// Configuration is written through i_cfg_wr_en/i_cfg_index/i_cfg_wdata
// (0: expect_downlink, 1: address_check_on, 2: target_address; index 3 is
// ignored). Write it only while no frame is in progress (not enforced).
module meter_frame_validator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mfv_in_if.sink                              i_rx,
    mfv_out_if.source                           o_res,
    input  logic                                i_cfg_wr_en,
    input  logic [mfv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mfv_pkg::ADDR_W-1:0]          i_cfg_wdata
);

    mfv_pkg::t_cfg         r_cfg;
    mfv_pkg::t_frame_state r_state;
    mfv_pkg::t_frame_state n_state;
    mfv_pkg::t_verdict     n_verdict;
    logic                  r_out_valid;
    logic [2:0]            r_out_status;
    logic [8:0]            r_out_len;
    logic                  in_accept;

    // Accept a byte whenever the output register is free or being drained
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign in_accept  = i_rx.valid && i_rx.ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mfv_pkg::CFG_EXPECT_DOWNLINK:  r_cfg.expect_downlink  <= i_cfg_wdata[0];
                mfv_pkg::CFG_ADDRESS_CHECK_ON: r_cfg.address_check_on <= i_cfg_wdata[0];
                mfv_pkg::CFG_TARGET_ADDRESS:   r_cfg.target_address   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    mfv_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_rx_byte    (i_rx.rx_byte),
        .i_buffer_end (i_rx.buffer_end),
        .o_state      (n_state),
        .o_verdict    (n_verdict)
    );

    // Advance the frame state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfv_pkg::FRAME_CLEAR;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Hold the verdict until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && n_verdict.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_verdict.valid) begin
            r_out_status <= n_verdict.status;
            r_out_len    <= n_verdict.frame_length;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.frame_length = r_out_len;

endmodule

// ===== rtl/mfv_checker.sv =====
// Port-level assertions for the meter frame validator, attached by bind.
// Depends on mfv_pkg and meter_frame_validator.
module mfv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_status,
    input logic [8:0] i_out_len
);

    // No verdict right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("verdict valid after reset");

    // Frame length only on ok or address mismatch, and then in range
    a_len_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_status == mfv_pkg::ST_OK ||
                          i_out_status == mfv_pkg::ST_ADDR_MISMATCH) ?
                         (i_out_len >= mfv_pkg::MIN_FRAME_W &&
                          i_out_len <= mfv_pkg::MAX_FRAME_W) :
                         (i_out_len == 9'd0)))
        else $error("frame length does not fit status");

    // Input is never stalled while the output register can drain
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with free output");

    // A verdict only appears after an accepted item
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !$past(i_out_valid && !i_out_ready)) |->
            $past(i_in_valid && i_in_ready))
        else $error("verdict without accepted item");

    // Stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_status) && $stable(i_out_len)))
        else $error("stalled verdict changed");

endmodule

bind meter_frame_validator mfv_checker u_mfv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_rx.valid),
    .i_in_ready   (i_rx.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_status (o_res.status),
    .i_out_len    (o_res.frame_length)
);
